/* hw/rtl/soc_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and handshake types of the segment occupancy collision check.
package soc_pkg;

   // map geometry and fixed-point format
   localparam int MAP_WIDTH  = 512;
   localparam int MAP_HEIGHT = 512;
   localparam int FRAC_BITS  = 4;
   localparam int MAP_CELLS  = MAP_WIDTH * MAP_HEIGHT;

   // field widths
   localparam int COORD_W = 13;
   localparam int CELL_W  = 9;

   // squared length: two 26-bit squares plus a carry, rounded up to an even width
   localparam int SQ_W   = 2 * COORD_W + 2;
   localparam int ROOT_W = SQ_W / 2;

   // request kinds carried on tuser
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_CHECK = 1'b1;

   typedef struct packed {
      logic            start;
      logic [SQ_W-1:0] value;
   } sqrt_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

endpackage

/* hw/rtl/segment_occupancy_collision_check_unit.sv */
`timescale 1ns / 1ps
// Top level: occupancy map, probe sequencer and segment sampling.
//
//   channel | direction | tdata                                    | tuser
//   req     | in        | 72b: cell_x, cell_y, static_bit,         | mode
//           |           |      dynamic_bit, start_x, start_y,      |
//           |           |      end_x, end_y                        |
//   rsp     | out       | 8b: collision, zero padded               | -
//
// A cell write does not leave the idle state; the block is ready again at once.
// A segment check reads the two endpoints while the squaring runs, waits for the
// square root, then makes one map read per sample (D - 1 samples).
// After reset the map is cleared one cell a cycle, all 262144 cells, with req_tready low.
// A finished check waits in its state while an earlier response is still held.
module segment_occupancy_collision_check_unit
   import soc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [8:0] cell_x, [17:9] cell_y, [18] static_bit, [19] dynamic_bit,
   // [32:20] start_x, [45:33] start_y, [58:46] end_x, [71:59] end_y
   input  logic [71:0] req_tdata,
   // [0] mode
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] collision, [7:1] zero
   output logic [7:0]  rsp_tdata
);

   localparam int  ADDR_W = $clog2(MAP_CELLS);
   localparam int  CX_W   = COORD_W - FRAC_BITS;
   localparam int  M_W    = ROOT_W + 1;
   localparam int  LOG_W  = $clog2(M_W);
   localparam int  ACC_W  = COORD_W + M_W;
   localparam int  SH_W   = $clog2(M_W + FRAC_BITS);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_MUL_X, ST_MUL_Y, ST_SQRT, ST_PREP, ST_SAMPLE, ST_DRAIN, ST_FINISH
   } state_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [31:0] x, input logic [31:0] y);
      cell_addr = ADDR_W'(y * 32'(MAP_WIDTH) + x);
   endfunction

   // request fields
   logic [CELL_W-1:0]  in_cell_x, in_cell_y;
   logic               in_static, in_dynamic;
   logic [COORD_W-1:0] in_sx, in_sy, in_ex, in_ey;

   assign in_cell_x  = req_tdata[8:0];
   assign in_cell_y  = req_tdata[17:9];
   assign in_static  = req_tdata[18];
   assign in_dynamic = req_tdata[19];
   assign in_sx      = req_tdata[32:20];
   assign in_sy      = req_tdata[45:33];
   assign in_ex      = req_tdata[58:46];
   assign in_ey      = req_tdata[71:59];

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [COORD_W-1:0] sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic [COORD_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [LOG_W-1:0]   log_d_ff, log_d_in;
   logic [M_W-1:0]     k_ff, k_in;
   logic [ACC_W-1:0]   acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic               coll_ff, coll_in;
   logic               probe_vld_ff, probe_vld_in;
   logic               probe_oob_ff, probe_oob_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic               rsp_coll_ff, rsp_coll_in;

   logic                 req_accept;
   logic [COORD_W-1:0]   mul_a;
   logic [2*COORD_W-1:0] prod;
   logic                 probe_en;
   logic [CX_W-1:0]      probe_x, probe_y;
   logic [SH_W-1:0]      shift;
   logic [M_W-1:0]       d_last;
   logic [M_W-1:0]       m_val;
   logic [LOG_W-1:0]     m_log;
   logic signed [COORD_W:0] dlt_x, dlt_y;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [1:0]           ram_wdata;
   logic [1:0]           ram_rdata;
   sqrt_req_type         sqrt_req;
   sqrt_rsp_type         sqrt_rsp;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // single squarer, shared between dx and dy
   assign mul_a = (state_ff == ST_MUL_X) ? dx_ff : dy_ff;
   assign prod  = mul_a * mul_a;

   assign sqrt_req.start = (state_ff == ST_MUL_Y);
   assign sqrt_req.value = sq_ff + SQ_W'(prod);

   // D = largest power of two not above floor(root / 2^(F+1)) + 2
   always_comb begin
      m_val = M_W'(sqrt_rsp.root >> (FRAC_BITS + 1)) + M_W'(2);
      m_log = '0;
      for (int i = 0; i < M_W; i++) begin
         if (m_val[i]) begin
            m_log = LOG_W'(i);
         end
      end
   end

   assign d_last = (M_W'(1) << log_d_ff) - M_W'(1);
   assign shift  = SH_W'(log_d_ff) + SH_W'(FRAC_BITS);
   assign dlt_x  = $signed({1'b0, sx_ff}) - $signed({1'b0, ex_ff});
   assign dlt_y  = $signed({1'b0, sy_ff}) - $signed({1'b0, ey_ff});

   // probe address selection
   always_comb begin
      probe_en = 1'b0;
      probe_x  = sx_ff[COORD_W-1:FRAC_BITS];
      probe_y  = sy_ff[COORD_W-1:FRAC_BITS];
      unique case (state_ff)
         ST_MUL_X: begin
            probe_en = 1'b1;
         end
         ST_MUL_Y: begin
            probe_en = 1'b1;
            probe_x  = ex_ff[COORD_W-1:FRAC_BITS];
            probe_y  = ey_ff[COORD_W-1:FRAC_BITS];
         end
         ST_SAMPLE: begin
            probe_en = 1'b1;
            probe_x  = CX_W'(acc_x_ff >> shift);
            probe_y  = CX_W'(acc_y_ff >> shift);
         end
         default: begin
            probe_en = 1'b0;
         end
      endcase
   end

   assign probe_vld_in = probe_en;
   // outside the map counts as occupied
   assign probe_oob_in = (32'(probe_x) >= 32'(MAP_WIDTH)) || (32'(probe_y) >= 32'(MAP_HEIGHT));

   // map write port: clearing pass or cell write
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = clr_ff;
      ram_wdata = '0;
      if (state_ff == ST_CLEAR) begin
         ram_we = 1'b1;
      end else if (req_accept && req_tuser == MODE_WRITE) begin
         ram_we    = (32'(in_cell_x) < 32'(MAP_WIDTH)) && (32'(in_cell_y) < 32'(MAP_HEIGHT));
         ram_waddr = cell_addr(32'(in_cell_x), 32'(in_cell_y));
         ram_wdata = {in_dynamic, in_static};
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      ex_in         = ex_ff;
      ey_in         = ey_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      sq_in         = sq_ff;
      log_d_in      = log_d_ff;
      k_in          = k_ff;
      acc_x_in      = acc_x_ff;
      acc_y_in      = acc_y_ff;
      coll_in       = coll_ff;
      rsp_coll_in   = rsp_coll_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      // fold in read data of the previous cycle's probe
      if (probe_vld_ff) begin
         coll_in = coll_ff || probe_oob_ff || (ram_rdata != 2'b00);
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(MAP_CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept && req_tuser == MODE_CHECK) begin
               sx_in    = in_sx;
               sy_in    = in_sy;
               ex_in    = in_ex;
               ey_in    = in_ey;
               dx_in    = (in_sx > in_ex) ? in_sx - in_ex : in_ex - in_sx;
               dy_in    = (in_sy > in_ey) ? in_sy - in_ey : in_ey - in_sy;
               coll_in  = 1'b0;
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            sq_in    = SQ_W'(prod);
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (sqrt_rsp.done) begin
               log_d_in = m_log;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // k = 1: (D-1)*end + start
            acc_x_in = (ACC_W'(ex_ff) << log_d_ff) - ACC_W'(ex_ff) + ACC_W'(sx_ff);
            acc_y_in = (ACC_W'(ey_ff) << log_d_ff) - ACC_W'(ey_ff) + ACC_W'(sy_ff);
            k_in     = M_W'(1);
            state_in = ST_SAMPLE;
         end
         ST_SAMPLE: begin
            acc_x_in = acc_x_ff + {{(ACC_W-COORD_W-1){dlt_x[COORD_W]}}, dlt_x};
            acc_y_in = acc_y_ff + {{(ACC_W-COORD_W-1){dlt_y[COORD_W]}}, dlt_y};
            k_in     = k_ff + M_W'(1);
            if (k_ff == d_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_coll_in   = coll_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         probe_vld_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         probe_vld_ff  <= probe_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      ex_ff        <= ex_in;
      ey_ff        <= ey_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sq_ff        <= sq_in;
      log_d_ff     <= log_d_in;
      k_ff         <= k_in;
      acc_x_ff     <= acc_x_in;
      acc_y_ff     <= acc_y_in;
      coll_ff      <= coll_in;
      probe_oob_ff <= probe_oob_in;
      rsp_coll_ff  <= rsp_coll_in;
   end

   soc_map_ram #(
      .DEPTH  (MAP_CELLS),
      .DATA_W (2)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cell_addr(32'(probe_x), 32'(probe_y))),
      .rd_data (ram_rdata)
   );

   soc_sqrt_unit u_sqrt_unit (
      .clock    (clock),
      .reset    (reset),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'b0, rsp_coll_ff};

   a_sqrt_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      sqrt_rsp.done |-> state_ff == ST_SQRT)
      else $error("square root finished outside its wait state");

   a_sample_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SAMPLE |-> log_d_ff != '0 && k_ff <= d_last && k_ff != '0)
      else $error("sample index out of range");

   a_probe_data_busy: assert property (@(posedge clock) disable iff (reset)
      probe_vld_ff |-> state_ff != ST_IDLE && state_ff != ST_CLEAR)
      else $error("probe data returned with no check in progress");

   a_no_write_in_check: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SAMPLE |=> !ram_we || state_ff == ST_IDLE)
      else $error("map written during a segment check");

endmodule

/* hw/rtl/soc_map_ram.sv */
`timescale 1ns / 1ps
// Simple dual-port RAM with one write port and one registered read port.
module soc_map_ram #(
   parameter  int DEPTH  = 16,
   parameter  int DATA_W = 2,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/soc_sqrt_unit.sv */
`timescale 1ns / 1ps
// Iterative integer square root, one result bit per cycle.
module soc_sqrt_unit
   import soc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  sqrt_req_type sqrt_req,
   output sqrt_rsp_type sqrt_rsp
);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [SQ_W-1:0] rem_ff, rem_in;
   logic [SQ_W-1:0] root_ff, root_in;
   logic [SQ_W-1:0] bit_ff, bit_in;
   logic [SQ_W-1:0] trial;

   // shared compare/subtract step
   assign trial = root_ff + bit_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      if (sqrt_req.start) begin
         busy_in = 1'b1;
         rem_in  = sqrt_req.value;
         root_in = '0;
         bit_in  = SQ_W'(1) << (SQ_W - 2);
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign sqrt_rsp.done = done_ff;
   assign sqrt_rsp.root = root_ff[ROOT_W-1:0];

   // the root always fits the lower ROOT_W + 1 bits of the word
   a_root_fits: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> root_ff[SQ_W-1:ROOT_W+1] == '0)
      else $error("square root overflowed its width");

   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !sqrt_req.start)
      else $error("square root restarted while busy");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("done without a finished iteration");

endmodule
